// File: design/z80_instruction_nop_count_defines.svh
// ----------------------------------------------------------------------------
// z80_instruction_nop_count_defines.svh
// Assertion macros used by the checker file of the NOP count decoder.
// ----------------------------------------------------------------------------
`ifndef Z80_INSTRUCTION_NOP_COUNT_DEFINES_SVH
`define Z80_INSTRUCTION_NOP_COUNT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ZNC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("znc assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ZNC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("znc assertion failed");

`endif

// File: design/znc_pkg.sv
// ----------------------------------------------------------------------------
// znc_pkg
// Types and opcode constants of the Z80 instruction NOP count decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package znc_pkg;

  // Prefix bytes
  localparam logic [7:0] OP_CB = 8'hCB;
  localparam logic [7:0] OP_DD = 8'hDD;
  localparam logic [7:0] OP_ED = 8'hED;
  localparam logic [7:0] OP_FD = 8'hFD;

  // Opcodes with timing of their own
  localparam logic [7:0] OP_DJNZ    = 8'h10;
  localparam logic [7:0] OP_LD_M_N  = 8'h36;
  localparam logic [7:0] OP_HALT    = 8'h76;
  localparam logic [7:0] OP_JP      = 8'hC3;
  localparam logic [7:0] OP_RET     = 8'hC9;
  localparam logic [7:0] OP_CALL    = 8'hCD;
  localparam logic [7:0] OP_EX_SP   = 8'hE3;
  localparam logic [7:0] OP_JP_HL   = 8'hE9;
  localparam logic [7:0] OP_EX_DE   = 8'hEB;
  localparam logic [7:0] OP_DI      = 8'hF3;
  localparam logic [7:0] OP_LD_SP   = 8'hF9;
  localparam logic [7:0] OP_EI      = 8'hFB;

  // ED block group: mask and match
  localparam logic [7:0] ED_BLK_MASK  = 8'hE4;
  localparam logic [7:0] ED_BLK_MATCH = 8'hA0;

  // Register index that selects (HL) / (IX+d)
  localparam logic [2:0] REG_MEM = 3'd6;

  // One input beat: the first four instruction bytes
  typedef struct packed {
    logic [7:0] byte_three;
    logic [7:0] byte_two;
    logic [7:0] byte_one;
    logic [7:0] byte_zero;
  } bytes_t;

  // One result beat
  typedef struct packed {
    logic       count_known;
    logic [2:0] nop_count;
  } result_t;

endpackage

`default_nettype wire

// File: design/znc_in_stage.sv
// ----------------------------------------------------------------------------
// znc_in_stage
// Input register: captures one beat of instruction bytes per cycle unless the held beat is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module znc_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire znc_pkg::bytes_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output znc_pkg::bytes_t      data_o
);
  import znc_pkg::*;

  logic   valid_q;
  logic   valid_d;
  bytes_t data_q;

  // Take a beat when empty or when the held one moves on
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: design/znc_decode.sv
// ----------------------------------------------------------------------------
// znc_decode
// Combinational decode of instruction bytes into a duration in NOP units.
// ----------------------------------------------------------------------------
`default_nettype none

module znc_decode (
  input  wire znc_pkg::bytes_t bytes_i,
  output znc_pkg::result_t     result_o
);
  import znc_pkg::*;

  // CB page
  function automatic logic [2:0] cb_count(input logic [7:0] op);
    logic [2:0] n;
    if (op[2:0] != REG_MEM) n = 3'd2;
    else if (op[7:6] == 2'b01) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

  // ED page; repeating block forms are unknown
  function automatic logic [2:0] ed_count(input logic [7:0] op);
    logic [2:0] n;
    if (op[7:6] == 2'b01) begin
      unique case (op[2:0]) inside
        3'd0, 3'd1, 3'd2, 3'd5: n = 3'd4;
        3'd3:                   n = 3'd6;
        3'd4, 3'd6:             n = 3'd2;
        default: begin
          if (!op[5]) n = 3'd3;
          else if (!op[4]) n = 3'd5;
          else n = 3'd2;
        end
      endcase
    end else if ((op & ED_BLK_MASK) == ED_BLK_MATCH) begin
      if (op[4]) n = 3'd0;
      else n = (op[1:0] == 2'd1) ? 3'd4 : 3'd5;
    end else begin
      n = 3'd2;
    end
    return n;
  endfunction

  // DD/FD page; op is the byte after the prefix
  function automatic logic [2:0] index_count(input logic [7:0] op, input logic [7:0] cb_op);
    logic [2:0] n;
    logic [2:0] lo;
    logic [2:0] mid;
    lo  = op[2:0];
    mid = op[5:3];
    if (op == OP_DD || op == OP_FD || op == OP_ED) begin
      n = 3'd1;
    end else if (op == OP_CB) begin
      n = (cb_op[7:6] == 2'b01) ? 3'd6 : 3'd7;
    end else begin
      unique case (op[7:6])
        2'b00: begin
          unique case (lo) inside
            3'd1:       n = 3'd4;
            3'd2:       n = (op[5:4] == 2'd2) ? 3'd6 : 3'd0;
            3'd3:       n = 3'd3;
            3'd4, 3'd5: n = (mid == REG_MEM) ? 3'd6 : 3'd2;
            3'd6:       n = (mid == REG_MEM) ? 3'd6 : 3'd3;
            default:    n = 3'd0;
          endcase
        end
        2'b01: n = (mid == REG_MEM || lo == REG_MEM) ? 3'd5 : 3'd2;
        2'b10: n = (lo == REG_MEM) ? 3'd5 : 3'd2;
        default: begin
          unique case (lo) inside
            3'd1: begin
              if (!op[3]) n = 3'd4;
              else if (op == OP_JP_HL) n = 3'd2;
              else if (op == OP_LD_SP) n = 3'd3;
              else n = 3'd0;
            end
            3'd3:    n = (op == OP_EX_SP) ? 3'd7 : 3'd0;
            3'd5:    n = !op[3] ? 3'd5 : 3'd0;
            default: n = 3'd0;
          endcase
        end
      endcase
    end
    return n;
  endfunction

  // Unprefixed page; JR cc, DJNZ, RET cc and CALL cc are unknown
  function automatic logic [2:0] main_count(input logic [7:0] op);
    logic [2:0] n;
    logic [2:0] lo;
    logic [2:0] mid;
    lo  = op[2:0];
    mid = op[5:3];
    unique case (op[7:6])
      2'b00: begin
        unique case (lo) inside
          3'd0: begin
            if (op[5]) n = 3'd0;                        // JR cc
            else if (op[4]) n = (op == OP_DJNZ) ? 3'd0 : 3'd3;
            else n = 3'd1;
          end
          3'd1: n = 3'd3;
          3'd2: begin
            unique case (op[5:4])
              2'd2:    n = 3'd5;
              2'd3:    n = 3'd4;
              default: n = 3'd2;
            endcase
          end
          3'd3:       n = 3'd2;
          3'd4, 3'd5: n = (mid == REG_MEM) ? 3'd3 : 3'd1;
          3'd6:       n = (op == OP_LD_M_N) ? 3'd3 : 3'd2;
          default:    n = 3'd1;
        endcase
      end
      2'b01: begin
        if (op == OP_HALT) n = 3'd1;
        else n = (mid == REG_MEM || lo == REG_MEM) ? 3'd2 : 3'd1;
      end
      2'b10: n = (lo == REG_MEM) ? 3'd2 : 3'd1;
      default: begin
        unique case (lo)
          3'd0: n = 3'd0;                               // RET cc
          3'd1: begin
            if (!op[3]) n = 3'd3;
            else if (op == OP_RET) n = 3'd3;
            else if (op == OP_LD_SP) n = 3'd2;
            else n = 3'd1;                              // EXX, JP (HL)
          end
          3'd2: n = 3'd3;
          3'd3: begin
            if (op[5:4] == 2'b01) n = 3'd3;
            else if (op == OP_JP) n = 3'd3;
            else if (op == OP_EX_SP) n = 3'd6;
            else if (op == OP_EX_DE || op == OP_DI || op == OP_EI) n = 3'd1;
            else n = 3'd0;
          end
          3'd4: n = 3'd0;                               // CALL cc
          3'd5: begin
            if (!op[3]) n = 3'd4;
            else n = (op == OP_CALL) ? 3'd5 : 3'd0;
          end
          3'd6:    n = 3'd2;
          default: n = 3'd4;
        endcase
      end
    endcase
    return n;
  endfunction

  logic [2:0] count;

  // Page select on the first byte
  always_comb begin
    unique case (bytes_i.byte_zero)
      OP_CB:        count = cb_count(bytes_i.byte_one);
      OP_DD, OP_FD: count = index_count(bytes_i.byte_one, bytes_i.byte_three);
      OP_ED:        count = ed_count(bytes_i.byte_one);
      default:      count = main_count(bytes_i.byte_zero);
    endcase
  end

  // Displacement byte plays no part in the duration
  assign result_o.nop_count   = count;
  assign result_o.count_known = (count != 3'd0);

endmodule

`default_nettype wire

// File: design/znc_out_stage.sv
// ----------------------------------------------------------------------------
// znc_out_stage
// Result register: holds one decoded beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module znc_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire znc_pkg::result_t result_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [7:0]            tdata_o
);
  import znc_pkg::*;

  logic    valid_q;
  logic    valid_d;
  result_t result_q;

  // Load when empty or when the sink takes the held beat
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

  // Pack: nop_count in [2:0], count_known in [3], zero pad above
  assign valid_o = valid_q;
  assign tdata_o = {4'b0000, result_q.count_known, result_q.nop_count};

endmodule

`default_nettype wire

// File: design/z80_instruction_nop_count.sv
// ----------------------------------------------------------------------------
// z80_instruction_nop_count
// Z80 instruction duration decoder, in NOP units.
// ----------------------------------------------------------------------------
// Send the first four bytes of an instruction as one input beat; one result
// beat comes back for it, and a new beat is taken every cycle while the
// output is not stalled. Each beat passes through the input register and
// the result register with the decode logic between them;
// tready on the input side follows m_axis_tready_i combinationally through
// both stages. Durations that depend on flags or repeat counts (JR cc, DJNZ,
// RET cc, CALL cc, repeating block instructions) and DD/FD forms outside the table
// come back as count 0 with the known bit low. Nothing is stored between
// instructions.
// ----------------------------------------------------------------------------
`default_nettype none

module z80_instruction_nop_count (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] byte_zero, [15:8] byte_one, [23:16] byte_two, [31:24] byte_three
  input  wire logic [31:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [2:0] nop_count, [3] count_known, [7:4] zero
  output logic [7:0]       m_axis_tdata_o
);
  import znc_pkg::*;

  bytes_t  in_bytes;
  bytes_t  reg_bytes;
  result_t dec_result;
  logic    reg_valid;
  logic    out_ready;

  assign in_bytes = bytes_t'(s_axis_tdata_i);

  // Input register
  znc_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (in_bytes),
    .valid_o (reg_valid),
    .ready_i (out_ready),
    .data_o  (reg_bytes)
  );

  // Decode
  znc_decode u_dec (
    .bytes_i  (reg_bytes),
    .result_o (dec_result)
  );

  // Result register
  znc_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (reg_valid),
    .ready_o  (out_ready),
    .result_i (dec_result),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// File: design/znc_checker.sv
// ----------------------------------------------------------------------------
// znc_checker
// Port-level checks of the NOP count decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "z80_instruction_nop_count_defines.svh"

module znc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [7:0]  m_axis_tdata_o
);

  // A stalled result beat stays put
  `ZNC_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // Input only backs up when both stages are full and the sink stalls
  `ZNC_ASSERT_IMPL(a_in_stall, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i)

  // Known bit agrees with a nonzero count
  `ZNC_ASSERT_IMPL(a_known, m_axis_tvalid_o, m_axis_tdata_o[3] == (m_axis_tdata_o[2:0] != 3'd0))

  // Padding bits stay zero
  `ZNC_ASSERT_IMPL(a_pad, m_axis_tvalid_o, m_axis_tdata_o[7:4] == 4'd0)

endmodule

bind z80_instruction_nop_count znc_checker u_znc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
